[hdl/sum_checked_display_frame_responder_assert.svh]
// Assertion macros shared by the frame responder modules.
// Each expects clk and rst_n in the scope where it is used.
`ifndef SUM_CHECKED_DISPLAY_FRAME_RESPONDER_ASSERT_SVH
`define SUM_CHECKED_DISPLAY_FRAME_RESPONDER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SCDFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SCDFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/scdfr_pkg.sv]
// Shared types, constants and lookup table of the display frame responder.
// No dependencies; the front, queue, back and top level refer to it by scoped names.
package scdfr_pkg;

    localparam int FRAME_BYTES       = 32;
    localparam int HANDSHAKE_ENTRIES = 64;
    localparam int HS_IDX_W          = 6;
    localparam int QUEUE_DEPTH       = 2;

    // frame and reply codes
    localparam logic [7:0] START_CODE     = 8'h3A;
    localparam logic [7:0] CMD_STATUS     = 8'h52;
    localparam logic [7:0] CMD_SETTINGS   = 8'h53;
    localparam logic [7:0] CMD_SETPOINT   = 8'h54;
    localparam logic [7:0] REPLY_ADDR     = 8'h1A;
    localparam logic [7:0] REPLY_SIZE     = 8'h05;
    localparam logic [7:0] STATE_BATT_LOW = 8'h40;
    localparam logic [7:0] HS_MARK        = 8'h0D;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [5:0] CUR_LIMIT_MASK = 6'h3F;
    localparam int         CUR_LIMIT_STEP = 500;

    // current * 3 / 10 as a multiply by 3 * ceil(2^16 / 10), exact below 1024
    localparam int DIV10_MUL   = 19662;
    localparam int DIV10_SHIFT = 16;

    // frame byte positions
    localparam int POS_CMD      = 2;
    localparam int POS_SIZE     = 3;
    localparam int POS_FLD_LO   = 4;
    localparam int POS_FLD_HI   = 13;
    localparam int POS_ASSIST   = 4;
    localparam int POS_RIDER    = 5;
    localparam int POS_SETPOINT = 4;
    localparam int POS_PAS      = 4;
    localparam int POS_MODE     = 6;
    localparam int POS_THROTTLE = 7;
    localparam int POS_CUR_LIM  = 8;
    localparam int POS_HS_INDEX = 9;
    localparam int POS_SPEED    = 11;
    localparam int POS_WHEEL_HI = 12;
    localparam int POS_WHEEL_LO = 13;
    localparam int FRAME_OVERHEAD = 6;

    // reply word indexes
    localparam int REPLY_IDX_W = 4;
    localparam logic [3:0] W_START  = 4'd0;
    localparam logic [3:0] W_ADDR   = 4'd1;
    localparam logic [3:0] W_CMD    = 4'd2;
    localparam logic [3:0] W_SIZE   = 4'd3;
    localparam logic [3:0] W_BODY0  = 4'd4;
    localparam logic [3:0] W_BODY1  = 4'd5;
    localparam logic [3:0] W_BODY2  = 4'd6;
    localparam logic [3:0] W_BODY3  = 4'd7;
    localparam logic [3:0] W_BODY4  = 4'd8;
    localparam logic [3:0] W_SUM_LO = 4'd9;
    localparam logic [3:0] W_SUM_HI = 4'd10;
    localparam logic [3:0] W_CR     = 4'd11;
    localparam logic [3:0] W_LF     = 4'd12;

    // reset values
    localparam logic [7:0]  RST_ASSIST   = 8'd128;
    localparam logic [7:0]  RST_RIDER    = 8'h0C;
    localparam logic [7:0]  RST_SETPOINT = 8'd255;
    localparam logic [7:0]  RST_SPEED    = 8'd250;
    localparam logic [14:0] RST_CUR_LIM  = 15'd150;
    localparam logic [15:0] RST_WHEEL    = 16'd2200;

    localparam logic [7:0] HS_TABLE [HANDSHAKE_ENTRIES] = '{
        8'd137, 8'd159, 8'd134, 8'd249, 8'd88,  8'd11,  8'd250, 8'd61,
        8'd33,  8'd150, 8'd3,   8'd193, 8'd118, 8'd141, 8'd209, 8'd94,
        8'd226, 8'd68,  8'd146, 8'd158, 8'd145, 8'd127, 8'd216, 8'd62,
        8'd116, 8'd230, 8'd101, 8'd211, 8'd251, 8'd54,  8'd229, 8'd247,
        8'd20,  8'd222, 8'd59,  8'd63,  8'd35,  8'd252, 8'd142, 8'd238,
        8'd23,  8'd197, 8'd84,  8'd77,  8'd147, 8'd173, 8'd210, 8'd57,
        8'd142, 8'd223, 8'd157, 8'd97,  8'd36,  8'd160, 8'd229, 8'd237,
        8'd75,  8'd80,  8'd37,  8'd113, 8'd154, 8'd88,  8'd23,  8'd120
    };

    typedef struct packed {
        logic [7:0]  assist_level;
        logic [7:0]  rider_flags;
        logic [7:0]  direct_setpoint;
        logic [7:0]  speed_limit;
        logic [14:0] current_limit_ma;
        logic [15:0] wheel_size_mm;
        logic [5:0]  setting_flags;
    } regs_t;

    // one queued result run: a 13-word reply or a single empty word
    typedef struct packed {
        logic            reply;
        logic            ok;
        logic [7:0]      cmd;
        logic [4:0][7:0] body;
        regs_t           regs;
    } job_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] tx_byte;
        logic       last_of_run;
        logic       frame_ok;
        logic [7:0] command_code;
        regs_t      regs;
    } out_word_t;

endpackage

[hdl/scdfr_channels.sv]
// Valid/ready channel interfaces of the frame responder.
// Depends on nothing; used by the front, back and top level.
interface scdfr_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic        battery_low;
    logic [9:0]  current_tenths;
    logic [15:0] wheel_time_ms;
    logic [7:0]  error_code;

    modport source (output valid, rx_byte, battery_low, current_tenths, wheel_time_ms,
                    error_code, input ready);
    modport sink (input valid, rx_byte, battery_low, current_tenths, wheel_time_ms,
                  error_code, output ready);
endinterface

interface scdfr_out_if;
    logic        valid;
    logic        ready;
    logic        has_byte;
    logic [7:0]  tx_byte;
    logic        last_of_run;
    logic        frame_ok;
    logic [7:0]  command_code;
    logic [7:0]  assist_level;
    logic [7:0]  rider_flags;
    logic [7:0]  direct_setpoint;
    logic [7:0]  speed_limit;
    logic [14:0] current_limit_ma;
    logic [15:0] wheel_size_mm;
    logic [5:0]  setting_flags;

    modport source (output valid, has_byte, tx_byte, last_of_run, frame_ok, command_code,
                    assist_level, rider_flags, direct_setpoint, speed_limit,
                    current_limit_ma, wheel_size_mm, setting_flags, input ready);
    modport sink (input valid, has_byte, tx_byte, last_of_run, frame_ok, command_code,
                  assist_level, rider_flags, direct_setpoint, speed_limit,
                  current_limit_ma, wheel_size_mm, setting_flags, output ready);
endinterface

[hdl/scdfr_queue.sv]
// Small job queue between the frame front and the reply back.
// Depends on scdfr_pkg for the job type.
module scdfr_queue #(
    parameter int DEPTH = scdfr_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  scdfr_pkg::job_t   push_job,
    output logic              pop_valid,
    input  logic              pop_ready,
    output scdfr_pkg::job_t   pop_job
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    scdfr_pkg::job_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push, pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hdl/scdfr_front.sv]
// Frame front: hunts the start code, collects and checks frames, updates
// the rider and setting registers and queues one job per finished or
// oversize frame. Depends on scdfr_pkg and scdfr_channels.
module scdfr_front #(
    parameter int FRAME_BYTES = scdfr_pkg::FRAME_BYTES
) (
    input  logic            clk,
    input  logic            rst_n,
    scdfr_in_if.sink        link,
    output logic            push_valid,
    input  logic            push_ready,
    output scdfr_pkg::job_t push_job
);
    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam logic [8:0] SIZE_MAX = 9'(FRAME_BYTES - scdfr_pkg::FRAME_OVERHEAD);
    localparam int LO = scdfr_pkg::POS_FLD_LO;
    localparam int HI = scdfr_pkg::POS_FLD_HI;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  assist_reg, assist_next;
    logic [7:0]  rider_reg, rider_next;
    logic [7:0]  setpoint_reg, setpoint_next;
    logic [7:0]  speed_limit_reg, speed_limit_next;
    logic [14:0] current_limit_reg, current_limit_next;
    logic [15:0] wheel_size_reg, wheel_size_next;
    logic [4:0]  settings_reg, settings_next;
    logic        autodetect_done_reg, autodetect_done_next;

    // frame payload, no reset
    logic [7:0] size_reg;
    logic [7:0] cmd_reg;
    logic [7:0] prev_reg;
    logic [7:0] fld_reg [LO:HI];
    logic [7:0] fb [LO:HI];

    logic        acc;
    logic [8:0]  pos9;
    logic        hunting;
    logic [7:0]  size_eff;
    logic        oversize;
    logic        frame_end;
    logic        ok;
    logic        is_status, is_settings, is_setpoint;
    logic        pulse;
    logic [24:0] cur_prod;
    logic [8:0]  cur_q;
    logic [7:0]  cur_byte;

    assign link.ready = push_ready;
    assign acc        = link.valid && link.ready;
    assign pos9       = 9'(pos_reg);
    assign hunting    = (pos_reg == '0) || (pos9 >= 9'(FRAME_BYTES));
    assign size_eff   = (pos_reg == POS_W'(scdfr_pkg::POS_SIZE)) ? link.rx_byte : size_reg;
    assign oversize   = !hunting && (pos_reg == POS_W'(scdfr_pkg::POS_SIZE))
                        && ({1'b0, link.rx_byte} > SIZE_MAX);
    assign frame_end  = !hunting && (pos9 > 9'(scdfr_pkg::POS_SIZE))
                        && (pos9 == 9'd5 + {1'b0, size_reg});
    // checksum closes on this byte (high) and the one before (low)
    assign ok         = sum_reg == {link.rx_byte, prev_reg};
    assign is_status   = frame_end && ok && (cmd_reg == scdfr_pkg::CMD_STATUS);
    assign is_settings = frame_end && ok && (cmd_reg == scdfr_pkg::CMD_SETTINGS);
    assign is_setpoint = frame_end && ok && (cmd_reg == scdfr_pkg::CMD_SETPOINT);
    assign pulse       = is_settings && fb[scdfr_pkg::POS_MODE][7] && !autodetect_done_reg;

    assign cur_prod = 25'(link.current_tenths) * 25'(scdfr_pkg::DIV10_MUL);
    assign cur_q    = cur_prod[scdfr_pkg::DIV10_SHIFT +: 9];
    assign cur_byte = (cur_q > 9'd255) ? 8'hFF : cur_q[7:0];

    // view of the store with the current byte already written
    always_comb
    begin
        for (int i = LO; i <= HI; i++)
        begin
            fb[i] = (pos_reg == POS_W'(i)) ? link.rx_byte : fld_reg[i];
        end
    end

    always_comb
    begin
        pos_next             = pos_reg;
        sum_next             = sum_reg;
        assist_next          = assist_reg;
        rider_next           = rider_reg;
        setpoint_next        = setpoint_reg;
        speed_limit_next     = speed_limit_reg;
        current_limit_next   = current_limit_reg;
        wheel_size_next      = wheel_size_reg;
        settings_next        = settings_reg;
        autodetect_done_next = autodetect_done_reg;
        if (acc)
        begin
            if (hunting)
            begin
                pos_next = '0;
                if (link.rx_byte == scdfr_pkg::START_CODE)
                begin
                    pos_next = POS_W'(1);
                    sum_next = '0;
                end
            end
            else if (oversize || frame_end)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                // header bytes always count; payload bytes up to the size
                if ((pos9 <= 9'(scdfr_pkg::POS_SIZE))
                    || (pos9 <= 9'd3 + {1'b0, size_eff}))
                begin
                    sum_next = sum_reg + 16'(link.rx_byte);
                end
            end
            if (is_status)
            begin
                assist_next = fb[scdfr_pkg::POS_ASSIST];
                rider_next  = fb[scdfr_pkg::POS_RIDER];
            end
            if (is_settings)
            begin
                settings_next = {fb[scdfr_pkg::POS_THROTTLE][6], fb[scdfr_pkg::POS_THROTTLE][7],
                                 fb[scdfr_pkg::POS_MODE][6], fb[scdfr_pkg::POS_MODE][7],
                                 fb[scdfr_pkg::POS_PAS][7]};
                speed_limit_next   = fb[scdfr_pkg::POS_SPEED];
                current_limit_next = 15'(fb[scdfr_pkg::POS_CUR_LIM][5:0]
                                         & scdfr_pkg::CUR_LIMIT_MASK)
                                     * 15'(scdfr_pkg::CUR_LIMIT_STEP);
                wheel_size_next    = {fb[scdfr_pkg::POS_WHEEL_HI], fb[scdfr_pkg::POS_WHEEL_LO]};
                if (pulse)
                begin
                    autodetect_done_next = 1'b1;
                end
            end
            if (is_setpoint)
            begin
                setpoint_next = fb[scdfr_pkg::POS_SETPOINT];
            end
        end
    end

    // job for the back: register fields show the values after this frame
    always_comb
    begin
        push_valid = acc && (oversize || frame_end);
        push_job.reply = is_status || is_settings;
        push_job.ok    = frame_end && ok;
        push_job.cmd   = cmd_reg;
        if (is_settings)
        begin
            push_job.body[0] = 8'h00;
            push_job.body[1] = 8'h00;
            push_job.body[2] = scdfr_pkg::HS_MARK;
            push_job.body[3] = scdfr_pkg::HS_TABLE[fb[scdfr_pkg::POS_HS_INDEX]
                                                    [scdfr_pkg::HS_IDX_W-1:0]];
            push_job.body[4] = 8'h00;
        end
        else
        begin
            push_job.body[0] = link.battery_low ? scdfr_pkg::STATE_BATT_LOW : 8'h00;
            push_job.body[1] = cur_byte;
            push_job.body[2] = link.wheel_time_ms[15:8];
            push_job.body[3] = link.wheel_time_ms[7:0];
            push_job.body[4] = link.error_code;
        end
        push_job.regs.assist_level     = assist_next;
        push_job.regs.rider_flags      = rider_next;
        push_job.regs.direct_setpoint  = setpoint_next;
        push_job.regs.speed_limit      = speed_limit_next;
        push_job.regs.current_limit_ma = current_limit_next;
        push_job.regs.wheel_size_mm    = wheel_size_next;
        push_job.regs.setting_flags    = {pulse, settings_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg             <= '0;
            sum_reg             <= '0;
            assist_reg          <= scdfr_pkg::RST_ASSIST;
            rider_reg           <= scdfr_pkg::RST_RIDER;
            setpoint_reg        <= scdfr_pkg::RST_SETPOINT;
            speed_limit_reg     <= scdfr_pkg::RST_SPEED;
            current_limit_reg   <= scdfr_pkg::RST_CUR_LIM;
            wheel_size_reg      <= scdfr_pkg::RST_WHEEL;
            settings_reg        <= '0;
            autodetect_done_reg <= 1'b0;
        end
        else
        begin
            pos_reg             <= pos_next;
            sum_reg             <= sum_next;
            assist_reg          <= assist_next;
            rider_reg           <= rider_next;
            setpoint_reg        <= setpoint_next;
            speed_limit_reg     <= speed_limit_next;
            current_limit_reg   <= current_limit_next;
            wheel_size_reg      <= wheel_size_next;
            settings_reg        <= settings_next;
            autodetect_done_reg <= autodetect_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && !hunting)
        begin
            prev_reg <= link.rx_byte;
            if (pos_reg == POS_W'(scdfr_pkg::POS_CMD))
            begin
                cmd_reg <= link.rx_byte;
            end
            if (pos_reg == POS_W'(scdfr_pkg::POS_SIZE))
            begin
                size_reg <= link.rx_byte;
            end
            for (int i = LO; i <= HI; i++)
            begin
                if (pos_reg == POS_W'(i))
                begin
                    fld_reg[i] <= link.rx_byte;
                end
            end
        end
    end

endmodule

[hdl/scdfr_back.sv]
// Reply back: takes jobs from the queue and streams their words through
// an output register. Depends on scdfr_pkg, scdfr_channels and the assert header.
`include "sum_checked_display_frame_responder_assert.svh"

module scdfr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  scdfr_pkg::job_t pop_job,
    scdfr_out_if.source     resp
);
    localparam int IDX_W = scdfr_pkg::REPLY_IDX_W;

    scdfr_pkg::job_t      job_reg, job_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [15:0]          chk_reg, chk_next;
    logic                 out_valid_reg, out_valid_next;
    scdfr_pkg::out_word_t out_word_reg, out_word_next;

    logic advance;
    logic last_word;
    logic load;

    assign advance   = cur_valid_reg && (!out_valid_reg || resp.ready);
    assign last_word = !job_reg.reply || (idx_reg == scdfr_pkg::W_LF);
    assign pop_ready = !cur_valid_reg || (advance && last_word);
    assign load      = pop_valid && pop_ready;

    // reply checksum over address, command, size and the five body bytes
    always_comb
    begin
        chk_next = 16'(scdfr_pkg::REPLY_ADDR) + 16'(pop_job.cmd) + 16'(scdfr_pkg::REPLY_SIZE);
        for (int i = 0; i < 5; i++)
        begin
            chk_next = chk_next + 16'(pop_job.body[i]);
        end
    end

    always_comb
    begin
        job_next       = job_reg;
        idx_next       = idx_reg;
        cur_valid_next = cur_valid_reg;
        if (advance)
        begin
            idx_next = idx_reg + 1'b1;
            if (last_word)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (load)
        begin
            job_next       = pop_job;
            idx_next       = '0;
            cur_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        out_word_next.has_byte     = job_reg.reply;
        out_word_next.last_of_run  = last_word;
        out_word_next.frame_ok     = job_reg.ok;
        out_word_next.command_code = job_reg.cmd;
        out_word_next.regs         = job_reg.regs;
        out_word_next.tx_byte      = 8'h00;
        if (job_reg.reply)
        begin
            case (idx_reg)
                scdfr_pkg::W_START:  out_word_next.tx_byte = scdfr_pkg::START_CODE;
                scdfr_pkg::W_ADDR:   out_word_next.tx_byte = scdfr_pkg::REPLY_ADDR;
                scdfr_pkg::W_CMD:    out_word_next.tx_byte = job_reg.cmd;
                scdfr_pkg::W_SIZE:   out_word_next.tx_byte = scdfr_pkg::REPLY_SIZE;
                scdfr_pkg::W_BODY0:  out_word_next.tx_byte = job_reg.body[0];
                scdfr_pkg::W_BODY1:  out_word_next.tx_byte = job_reg.body[1];
                scdfr_pkg::W_BODY2:  out_word_next.tx_byte = job_reg.body[2];
                scdfr_pkg::W_BODY3:  out_word_next.tx_byte = job_reg.body[3];
                scdfr_pkg::W_BODY4:  out_word_next.tx_byte = job_reg.body[4];
                scdfr_pkg::W_SUM_LO: out_word_next.tx_byte = chk_reg[7:0];
                scdfr_pkg::W_SUM_HI: out_word_next.tx_byte = chk_reg[15:8];
                scdfr_pkg::W_CR:     out_word_next.tx_byte = scdfr_pkg::BYTE_CR;
                scdfr_pkg::W_LF:     out_word_next.tx_byte = scdfr_pkg::BYTE_LF;
                default:             out_word_next.tx_byte = 8'h00;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (resp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (load)
        begin
            chk_reg <= chk_next;
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign resp.valid            = out_valid_reg;
    assign resp.has_byte         = out_word_reg.has_byte;
    assign resp.tx_byte          = out_word_reg.tx_byte;
    assign resp.last_of_run      = out_word_reg.last_of_run;
    assign resp.frame_ok         = out_word_reg.frame_ok;
    assign resp.command_code     = out_word_reg.command_code;
    assign resp.assist_level     = out_word_reg.regs.assist_level;
    assign resp.rider_flags      = out_word_reg.regs.rider_flags;
    assign resp.direct_setpoint  = out_word_reg.regs.direct_setpoint;
    assign resp.speed_limit      = out_word_reg.regs.speed_limit;
    assign resp.current_limit_ma = out_word_reg.regs.current_limit_ma;
    assign resp.wheel_size_mm    = out_word_reg.regs.wheel_size_mm;
    assign resp.setting_flags    = out_word_reg.regs.setting_flags;

    `SCDFR_ASSERT_NOW(a_empty_closes_run, resp.valid && !resp.has_byte, resp.last_of_run, "empty word not marked last")
    `SCDFR_ASSERT_NOW(a_idx_in_reply, cur_valid_reg, idx_reg <= scdfr_pkg::W_LF, "reply index past line feed")
    `SCDFR_ASSERT_NOW(a_no_job_dropped, load && cur_valid_reg, advance && last_word, "job replaced before its last word")

endmodule

[hdl/sum_checked_display_frame_responder.sv]
// Top level of the display link frame responder.
// Depends on scdfr_pkg, scdfr_channels, scdfr_front, scdfr_queue and scdfr_back.
// Usage:
//   link carries one received byte per word together with a telemetry
//   snapshot (battery flag, motor current, wheel time, error code). resp
//   carries result words: reply bytes with has_byte set, or one empty word
//   per frame that gives no reply. last_of_run closes the words of one frame.
// Timing:
//   The front takes a byte every cycle while the job queue has room. A
//   frame's first result word reaches resp through the queue write, the
//   job load and the output register after its closing byte is taken. A
//   reply then streams 13 words; an empty result is one word. Sustained
//   rate is set by the back: it streams every word of a result before it
//   takes the next job; the front keeps one byte per cycle otherwise.
// Reset:
//   rst_n clears the frame hunt, the checksum and the rider and setting
//   registers to their defaults; stored frame bytes stay undefined.
// Stall:
//   When resp.ready is low the output word holds, the back stops, the queue
//   fills and link.ready drops once the queue is full.
module sum_checked_display_frame_responder #(
    parameter int FRAME_BYTES = scdfr_pkg::FRAME_BYTES,
    parameter int QUEUE_DEPTH = scdfr_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    scdfr_in_if.sink    link,
    scdfr_out_if.source resp
);
    scdfr_pkg::job_t push_job;
    scdfr_pkg::job_t pop_job;
    logic            push_valid, push_ready;
    logic            pop_valid, pop_ready;

    // classify bytes and update registers
    scdfr_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .link       (link),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // decouple the front from a stalled receiver
    scdfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // expand jobs into result words
    scdfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .resp      (resp)
    );

endmodule
